[hw/rtl/chip8_pkg.sv]
`default_nettype none
package chip8_pkg;

  localparam int unsigned AddrW = 12;
  localparam logic [AddrW-1:0] StartPc = 12'h200;
  localparam logic [AddrW-1:0] FontBase = 12'h050;
  localparam int unsigned FontBytes = 80;

  typedef enum logic [1:0] {
    ModeLoad = 2'd0,
    ModeExec = 2'd1,
    ModeRow  = 2'd2,
    ModeNone = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] address;
    logic [7:0]  data;
    logic [15:0] keys;
    logic [7:0]  random;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] row_data;
    logic [11:0] program_counter;
    logic [15:0] instruction;
    logic        drew;
    logic        sound_on;
    logic        waiting_key;
  } out_beat_t;

  typedef enum logic [3:0] {
    StIdle, StClear, StFetchHi, StFetchLo, StDecode, StDraw, StDrawWr,
    StBcd, StBlock, StBlockWr, StFinish, StOut
  } ctrl_state_e;

  typedef enum logic [2:0] {
    CmdNone, CmdFetchHi, CmdFetchLo, CmdExec, CmdDraw, CmdBcd, CmdBlock, CmdFinish
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e     cmd;
    logic [4:0]  step;
    logic        clear_mem;
    logic [11:0] clear_addr;
    logic        latch_in;
  } dp_ctrl_t;

  typedef struct packed {
    logic [3:0] op_class;
    logic [7:0] kk;
    logic [3:0] n;
    logic [3:0] x;
    logic [4:0] draw_rows;
  } dp_stat_t;

  function automatic logic [7:0] font_byte(input logic [6:0] i);
    logic [7:0] f [FontBytes];
    f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
          8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
          8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
          8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
          8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
          8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
          8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
          8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
    if (i < 7'(FontBytes)) begin
      return f[i];
    end
    return 8'h00;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/chip8_ctrl.sv]
`default_nettype none
module chip8_ctrl
  import chip8_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic [1:0] in_mode_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_ctrl_t      ctrl_o
);

  ctrl_state_e state_q, state_d;
  logic [11:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    ctrl_o = '0;
    ctrl_o.cmd = CmdNone;
    ctrl_o.step = cnt_q[4:0];
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StClear: begin
        ctrl_o.clear_mem = 1'b1;
        ctrl_o.clear_addr = cnt_q;
        cnt_d = cnt_q + 12'd1;
        if (cnt_q == 12'hFFF) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        cnt_d = '0;
        if (in_valid_i) begin
          ctrl_o.latch_in = 1'b1;
          if (mode_e'(in_mode_i) == ModeExec) begin
            state_d = StFetchHi;
          end else begin
            state_d = StOut;
          end
        end
      end
      StFetchHi: begin
        ctrl_o.cmd = CmdFetchHi;
        state_d = StFetchLo;
      end
      StFetchLo: begin
        ctrl_o.cmd = CmdFetchLo;
        state_d = StDecode;
      end
      StDecode: begin
        ctrl_o.cmd = CmdExec;
        if (stat_i.op_class == 4'hD) begin
          state_d = (stat_i.draw_rows == 5'd0) ? StFinish : StDraw;
        end else if (stat_i.op_class == 4'hF && stat_i.kk == 8'h33) begin
          state_d = StBcd;
        end else if (stat_i.op_class == 4'hF &&
                     (stat_i.kk == 8'h55 || stat_i.kk == 8'h65)) begin
          state_d = StBlock;
        end else begin
          state_d = StFinish;
        end
      end
      StDraw: begin
        // memory read of sprite row issued
        state_d = StDrawWr;
      end
      StDrawWr: begin
        ctrl_o.cmd = CmdDraw;
        cnt_d = cnt_q + 12'd1;
        state_d = (cnt_q[4:0] + 5'd1 == stat_i.draw_rows) ? StFinish : StDraw;
      end
      StBcd: begin
        ctrl_o.cmd = CmdBcd;
        cnt_d = cnt_q + 12'd1;
        if (cnt_q[1:0] == 2'd2) begin
          state_d = StFinish;
        end
      end
      StBlock: begin
        state_d = StBlockWr;
      end
      StBlockWr: begin
        ctrl_o.cmd = CmdBlock;
        cnt_d = cnt_q + 12'd1;
        state_d = (cnt_q[3:0] == stat_i.x) ? StFinish : StBlock;
      end
      StFinish: begin
        ctrl_o.cmd = CmdFinish;
        state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle) else $error("ready outside idle");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready with valid");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("valid dropped");
`endif

endmodule
`default_nettype wire

[hw/rtl/chip8_dp.sv]
`default_nettype none
module chip8_dp
  import chip8_pkg::*;
#(
  parameter int unsigned StackDepth = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_beat_t in_i,
  input  wire dp_ctrl_t ctrl_i,
  output dp_stat_t      stat_o,
  output out_beat_t     out_o
);

  localparam int unsigned SpW = $clog2(StackDepth);

  logic [7:0]  mem [4096];
  logic [63:0] disp_q [32];
  logic [7:0]  v_q [16];
  logic [11:0] stk [StackDepth];
  logic [11:0] i_q, pc_q;
  logic [SpW-1:0] sp_q;
  logic [7:0]  dt_q, st_q;
  in_beat_t    in_q;
  logic [15:0] op_q;
  logic [7:0]  rd_q;
  logic [63:0] row_q;
  logic        drew_q, wait_q;
  logic [7:0]  bcd_q [3];
  logic [5:0]  px_q;
  logic [4:0]  py_q;

  logic [15:0] op_w;
  logic [3:0] x, y, n;
  logic [7:0] kk, vx, vy;
  logic [11:0] nnn;
  logic [4:0] py, prow;
  logic [5:0] rows_left;
  logic [11:0] rd_addr, wr_addr;
  logic        wr_en;
  logic [7:0]  wr_data;
  logic [63:0] spr;
  logic [4:0]  key_idx;
  logic        key_any;
  logic [SpW-1:0] sp_dec;
  logic [1:0]  bcd_h;
  logic [6:0]  bcd_r;
  logic [14:0] bcd_m;
  logic [3:0]  bcd_t, bcd_o;

  // The low opcode byte is still in the read register while the
  // instruction executes; it is captured into op_q at the same edge.
  assign op_w = (ctrl_i.cmd == CmdExec) ? {op_q[15:8], rd_q} : op_q;
  assign x = op_w[11:8];
  assign y = op_w[7:4];
  assign n = op_w[3:0];
  assign kk = op_w[7:0];
  assign nnn = op_w[11:0];
  assign vx = v_q[x];
  assign vy = v_q[y];
  assign py = (ctrl_i.cmd == CmdExec) ? vy[4:0] : py_q;
  assign rows_left = 6'd32 - {1'b0, py};
  assign prow = py_q + ctrl_i.step;
  assign sp_dec = (sp_q == '0) ? SpW'(StackDepth - 1) : sp_q - 1'b1;

  assign stat_o.op_class = op_w[15:12];
  assign stat_o.kk = kk;
  assign stat_o.n = n;
  assign stat_o.x = x;
  assign stat_o.draw_rows = ({2'b0, n} < rows_left) ? {1'b0, n} : rows_left[4:0];

  always_comb begin
    key_idx = 5'd16;
    for (int k = 15; k >= 0; k--) begin
      if (in_q.keys[k]) begin
        key_idx = 5'(k);
      end
    end
    key_any = |in_q.keys;
  end

  // Decimal digits of Vx: hundreds by compare and subtract, tens by a
  // reciprocal multiply that is exact below 100.
  always_comb begin
    if (vx >= 8'd200) begin
      bcd_h = 2'd2;
      bcd_r = 7'(vx - 8'd200);
    end else if (vx >= 8'd100) begin
      bcd_h = 2'd1;
      bcd_r = 7'(vx - 8'd100);
    end else begin
      bcd_h = 2'd0;
      bcd_r = vx[6:0];
    end
    bcd_m = {8'd0, bcd_r} * 15'd205;
    bcd_t = bcd_m[14:11];
    bcd_o = 4'(bcd_r - {bcd_t, 3'd0} - {2'd0, bcd_t, 1'b0});
  end

  // Memory port addressing.
  always_comb begin
    rd_addr = pc_q;
    wr_en = 1'b0;
    wr_addr = in_i.address;
    wr_data = in_i.data;
    case (ctrl_i.cmd)
      CmdFetchHi: rd_addr = pc_q;
      CmdFetchLo: rd_addr = pc_q + 12'd1;
      default: rd_addr = i_q + {7'd0, ctrl_i.step};
    endcase
    if (ctrl_i.clear_mem) begin
      wr_en = 1'b1;
      wr_addr = ctrl_i.clear_addr;
      wr_data = (ctrl_i.clear_addr >= FontBase && ctrl_i.clear_addr < FontBase + 12'd80) ?
                font_byte(7'(ctrl_i.clear_addr - FontBase)) : 8'h00;
    end else if (ctrl_i.latch_in && mode_e'(in_i.mode) == ModeLoad) begin
      wr_en = 1'b1;
    end else if (ctrl_i.cmd == CmdBcd) begin
      wr_en = 1'b1;
      wr_addr = i_q + {10'd0, ctrl_i.step[1:0]};
      wr_data = bcd_q[ctrl_i.step[1:0]];
    end else if (ctrl_i.cmd == CmdBlock && kk == 8'h55) begin
      wr_en = 1'b1;
      wr_addr = i_q + {8'd0, ctrl_i.step[3:0]};
      wr_data = v_q[ctrl_i.step[3:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign spr = {rd_q, 56'd0} >> px_q;

  // The sprite origin is taken before VF is cleared, so a draw through VF
  // keeps its original position.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      in_q <= in_i;
    end
    if (ctrl_i.cmd == CmdExec) begin
      bcd_q[0] <= {6'd0, bcd_h};
      bcd_q[1] <= {4'd0, bcd_t};
      bcd_q[2] <= {4'd0, bcd_o};
      px_q <= vx[5:0];
      py_q <= vy[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 32; r++) disp_q[r] <= '0;
      for (int r = 0; r < 16; r++) v_q[r] <= '0;
      for (int r = 0; r < StackDepth; r++) stk[r] <= '0;
      i_q <= '0;
      pc_q <= StartPc;
      sp_q <= '0;
      dt_q <= '0;
      st_q <= '0;
      op_q <= '0;
      row_q <= '0;
      drew_q <= 1'b0;
      wait_q <= 1'b0;
    end else begin
      if (ctrl_i.latch_in) begin
        op_q <= '0;
        drew_q <= 1'b0;
        wait_q <= 1'b0;
        row_q <= (mode_e'(in_i.mode) == ModeRow) ? disp_q[in_i.address[4:0]] : 64'd0;
      end
      case (ctrl_i.cmd)
        CmdFetchLo: op_q[15:8] <= rd_q;
        CmdExec: op_q[7:0] <= rd_q;
        default: ;
      endcase
      if (ctrl_i.cmd == CmdDraw) begin
        if ((disp_q[prow] & spr) != 64'd0) v_q[15] <= 8'd1;
        disp_q[prow] <= disp_q[prow] ^ spr;
      end
      if (ctrl_i.cmd == CmdBlock && kk == 8'h65) begin
        v_q[ctrl_i.step[3:0]] <= rd_q;
      end
      if (ctrl_i.cmd == CmdFinish) begin
        dt_q <= (dt_q != 0) ? dt_q - 8'd1 : dt_q;
        st_q <= (st_q != 0) ? st_q - 8'd1 : st_q;
      end
      if (ctrl_i.cmd == CmdExec) begin
        pc_q <= pc_q + 12'd2;
        case (op_w[15:12])
          4'h0: begin
            if (nnn == 12'h0E0) begin
              for (int r = 0; r < 32; r++) disp_q[r] <= '0;
            end else if (nnn == 12'h0EE) begin
              sp_q <= sp_dec;
              pc_q <= stk[sp_dec];
            end
          end
          4'h1: pc_q <= nnn;
          4'h2: begin
            stk[sp_q] <= pc_q + 12'd2;
            sp_q <= (SpW'(sp_q) == SpW'(StackDepth - 1)) ? '0 : sp_q + 1'b1;
            pc_q <= nnn;
          end
          4'h3: if (vx == kk) pc_q <= pc_q + 12'd4;
          4'h4: if (vx != kk) pc_q <= pc_q + 12'd4;
          4'h5: if (vx == vy) pc_q <= pc_q + 12'd4;
          4'h6: v_q[x] <= kk;
          4'h7: v_q[x] <= vx + kk;
          4'h8: begin
            case (n)
              4'h0: v_q[x] <= vy;
              4'h1: v_q[x] <= vx | vy;
              4'h2: v_q[x] <= vx & vy;
              4'h3: v_q[x] <= vx ^ vy;
              4'h4: begin
                v_q[15] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'd255};
                v_q[x] <= vx + vy;
              end
              4'h5: begin
                v_q[15] <= {7'd0, vx > vy};
                v_q[x] <= vx - vy;
              end
              4'h6: begin
                v_q[15] <= {7'd0, vx[0]};
                v_q[x] <= vx >> 1;
              end
              4'h7: begin
                v_q[15] <= {7'd0, vy > vx};
                v_q[x] <= vy - vx;
              end
              4'hE: begin
                v_q[15] <= {7'd0, vx[7]};
                v_q[x] <= vx << 1;
              end
              default: ;
            endcase
          end
          4'h9: if (vx != vy) pc_q <= pc_q + 12'd4;
          4'hA: i_q <= nnn;
          4'hB: pc_q <= nnn + {4'd0, v_q[0]};
          4'hC: v_q[x] <= in_q.random & kk;
          4'hD: begin
            drew_q <= 1'b1;
            v_q[15] <= 8'd0;
          end
          4'hE: begin
            if (kk == 8'h9E && vx < 8'd16 && in_q.keys[vx[3:0]]) pc_q <= pc_q + 12'd4;
            else if (kk == 8'hA1 && !(vx < 8'd16 && in_q.keys[vx[3:0]]))
              pc_q <= pc_q + 12'd4;
          end
          default: begin
            case (kk)
              8'h07: v_q[x] <= dt_q;
              8'h0A: begin
                if (key_any) v_q[x] <= {4'd0, key_idx[3:0]};
                else begin
                  pc_q <= pc_q;
                  wait_q <= 1'b1;
                end
              end
              8'h15: dt_q <= vx;
              8'h18: st_q <= vx;
              8'h1E: i_q <= i_q + {4'd0, vx};
              8'h29: i_q <= FontBase + {2'd0, vx, 2'd0} + {4'd0, vx};
              default: ;
            endcase
          end
        endcase
      end
    end
  end

  assign out_o.row_data = row_q;
  assign out_o.program_counter = pc_q;
  assign out_o.instruction = op_q;
  assign out_o.drew = drew_q;
  assign out_o.sound_on = st_q != 8'd0;
  assign out_o.waiting_key = wait_q;

endmodule
`default_nettype wire

[hw/rtl/vm_cpu_core_16bit_opcode_core.sv]
`default_nettype none
// Interpreter core for a 16-bit opcode virtual machine.
// Input beats arrive on in_valid_i/in_ready_o with one in_beat_t payload.
// Mode load writes a byte to the 4096-byte program memory, mode execute
// runs one full instruction, and mode row reads one 64-pixel display row.
// Every input beat yields exactly one output beat on out_valid_o/out_ready_i.
// One beat is in flight at a time: the input is taken only while idle.
// Load, row and unused-mode beats present their result the cycle after the
// input beat is taken. An instruction passes from accept to accept through
// idle, high and low fetch, execute, timer update and result, plus a read
// and a write state per sprite row drawn, a store of each of the three BCD
// digits and a read and a write state per register for block load or store,
// all set by memory access. After reset the core sweeps the memory to
// install the font and zero the rest, and accepts no beat during that pass.
// A stalled receiver holds the result; the core then accepts no input.
module vm_cpu_core_16bit_opcode_core
  import chip8_pkg::*;
#(
  parameter int unsigned StackDepth = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  chip8_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .in_mode_i(in_data_i.mode),
    .out_valid_o, .out_ready_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  chip8_dp #(.StackDepth(StackDepth)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .ctrl_i(ctrl),
    .stat_o(stat), .out_o(out_data_o)
  );

endmodule
`default_nettype wire
